/* src/channel_busy_percentage_meter_core_assert.svh */
// ----------------------------------------------------------------------------
// Channel busy percentage meter assertion macros
// Shared property macros for the checks at the end of the core RTL module.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_BUSY_PERCENTAGE_METER_CORE_ASSERT_SVH
`define CHANNEL_BUSY_PERCENTAGE_METER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CBPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbpm check failed");

// The consequent holds in the cycle after the antecedent.
`define CBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbpm check failed");

`endif

/* src/cbpm_pkg.sv */
// ----------------------------------------------------------------------------
// Channel busy percentage meter package
// Request and result types, state encoding and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none
package cbpm_pkg;

  typedef struct packed {
    logic        action;
    logic        channel_busy;
    logic [31:0] now_time;
  } cbpm_in_t;

  typedef struct packed {
    logic [14:0] raw_percent;
    logic [14:0] smoothed_percent;
    logic [47:0] total_busy;
  } cbpm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCALE,
    ST_DIV,
    ST_AVG_MUL,
    ST_AVG_SUM
  } cbpm_state_t;

  localparam logic ACTION_REPORT = 1'b0;
  localparam logic ACTION_QUERY  = 1'b1;

  localparam logic [1:0] CFG_WINDOW_PERIOD = 2'd0;
  localparam logic [1:0] CFG_WEIGHT_FACTOR = 2'd1;

  localparam logic [14:0] PCT_FULL       = 15'd25600;
  localparam logic [47:0] TOTAL_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam logic [16:0] WEIGHT_ONE     = 17'd65536;
  localparam logic [32:0] ROUND_HALF     = 33'd32768;
  localparam logic [31:0] PERIOD_RESET   = 32'd100000;
  localparam logic [16:0] WEIGHT_RESET   = 17'd32768;
  localparam logic [3:0]  DIV_TOP_BIT    = 4'd14;

endpackage
`default_nettype wire

/* src/cbpm_interval_ram.sv */
// ----------------------------------------------------------------------------
// Interval store
// Single write port, single read port memory holding the start and end time
// of each finished busy interval; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpm_interval_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [63:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [63:0]   rd_data
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/channel_busy_percentage_meter_core.sv */
// ----------------------------------------------------------------------------
// Channel busy percentage meter core
// Tracks channel busy intervals and answers busy percentage queries with a
// raw and an exponentially averaged figure.
//
//   Channel  Ports                          Handshake
//   input    start, busy, in_req            start and not busy
//   result   out_strobe, out_result         one-cycle strobe
//   config   cfg_we, cfg_index, cfg_wdata   write enable
//
// Busy stays low for a report. A query with a nonzero period holds busy
// through one pass over the interval memory at one read a cycle, the registered
// last read, one scaling step, fifteen divide steps and two averaging steps.
// When the busy time is zero or fills the window, the divide steps are skipped.
// A query with a zero period is answered in the next cycle. Reset is synchronous
// and needs no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none
module channel_busy_percentage_meter_core #(
  parameter int MAX_INTERVALS = 64,
  parameter longint unsigned RETAIN_TICKS = 6000000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cbpm_pkg::cbpm_in_t   in_req,
  output logic                      out_strobe,
  output cbpm_pkg::cbpm_out_t       out_result,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_wdata
);
  import cbpm_pkg::*;

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_INTERVALS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(MAX_INTERVALS);
  localparam logic [33:0] RETAIN34 = 34'(RETAIN_TICKS);

  cbpm_state_t state_r, state_nxt;

  logic [31:0] period_r;
  logic [16:0] weight_r;
  logic        busy_flag_r, idle_flag_r;
  logic [31:0] busy_start_r;
  logic [47:0] total_r;
  logic [MAX_INTERVALS-1:0] valid_r;
  logic [AW-1:0] head_r;
  logic [14:0] prev_r;
  logic [31:0] last_clean_r;

  logic [33:0] now_r, ws_r, limit_r;
  logic        clean_en_r;
  logic [47:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic        proc_vld_r;
  logic [AW-1:0] proc_idx_r;
  logic [46:0] rem_r;
  logic [14:0] raw_r;
  logic [3:0]  bit_r;
  logic [31:0] p1_r;
  logic        out_strobe_r;
  cbpm_out_t   out_result_r;

  logic        acc_in, is_report, is_query, store_now;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  logic [63:0] wr_data, rd_data;

  logic [33:0] seg_s, seg_e, seg_delta;
  logic        seg_add;
  logic [32:0] open_len;
  logic [33:0] since_clean;
  logic [32:0] total_sum;
  logic [31:0] iv_len;
  logic        acc_pos, acc_lt;
  logic [46:0] scale_prod, div_sub;
  logic        div_ge;
  logic [16:0] w_cl, w_inv;
  logic [32:0] avg_sum;
  logic [16:0] avg_q;
  logic [14:0] smooth;

  assign acc_in    = start && !busy;
  assign is_report = acc_in && (in_req.action == ACTION_REPORT);
  assign is_query  = acc_in && (in_req.action == ACTION_QUERY);
  assign store_now = is_report && !in_req.channel_busy && !idle_flag_r && busy_flag_r;

  assign iv_len    = in_req.now_time - busy_start_r;
  assign total_sum = {1'b0, total_r[31:0]} + {1'b0, iv_len};
  assign open_len  = {1'b0, in_req.now_time} - {1'b0, busy_start_r};
  assign since_clean = {2'b0, in_req.now_time} - {2'b0, last_clean_r};

  assign seg_s = {2'b0, rd_data[63:32]};
  assign seg_e = {2'b0, rd_data[31:0]};

  always_comb begin
    seg_add   = 1'b0;
    seg_delta = '0;
    if (($signed(seg_s) >= $signed(ws_r)) && ($signed(seg_s) <= $signed(now_r))) begin
      seg_add   = 1'b1;
      seg_delta = seg_e - seg_s;
    end else if (($signed(seg_s) < $signed(ws_r)) && ($signed(seg_e) > $signed(ws_r))) begin
      seg_add   = 1'b1;
      seg_delta = seg_e - ws_r;
    end
  end

  assign acc_pos    = !acc_r[47] && (acc_r != '0);
  assign acc_lt     = acc_r < {16'b0, period_r};
  assign scale_prod = acc_r[31:0] * PCT_FULL;
  assign div_sub    = {15'b0, period_r} << bit_r;
  assign div_ge     = rem_r >= div_sub;

  assign w_cl    = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_inv   = WEIGHT_ONE - w_cl;
  assign avg_sum = {1'b0, p1_r} + 33'(w_inv * prev_r) + ROUND_HALF;
  assign avg_q   = avg_sum[32:16];
  assign smooth  = (avg_q > {2'b0, PCT_FULL}) ? PCT_FULL : avg_q[14:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_query && (period_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (proc_vld_r && (proc_idx_r == LAST_IDX)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_nxt = (acc_pos && acc_lt) ? ST_DIV : ST_AVG_MUL;
      end
      ST_DIV: begin
        if (bit_r == '0) begin
          state_nxt = ST_AVG_MUL;
        end
      end
      ST_AVG_MUL: state_nxt = ST_AVG_SUM;
      ST_AVG_SUM: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_r != ST_IDLE);
    rd_en   = (state_r == ST_SCAN) && (cnt_r < CNT_END);
    rd_addr = cnt_r[AW-1:0];
    wr_en   = store_now;
    wr_data = {busy_start_r, in_req.now_time};
  end

  cbpm_interval_ram #(
    .DEPTH (MAX_INTERVALS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      period_r     <= PERIOD_RESET;
      weight_r     <= WEIGHT_RESET;
      busy_flag_r  <= 1'b0;
      idle_flag_r  <= 1'b0;
      busy_start_r <= '0;
      total_r      <= '0;
      valid_r      <= '0;
      head_r       <= '0;
      prev_r       <= '0;
      last_clean_r <= '0;
      proc_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      proc_vld_r   <= rd_en;
      proc_idx_r   <= rd_addr;

      if (cfg_we) begin
        if (cfg_index == CFG_WINDOW_PERIOD) begin
          period_r <= cfg_wdata;
        end else if (cfg_index == CFG_WEIGHT_FACTOR) begin
          weight_r <= cfg_wdata[16:0];
        end
      end

      if (is_report) begin
        if (in_req.channel_busy) begin
          if (!busy_flag_r) begin
            busy_start_r <= in_req.now_time;
          end
          busy_flag_r <= 1'b1;
          idle_flag_r <= 1'b0;
        end else begin
          if (store_now) begin
            valid_r[head_r] <= 1'b1;
            head_r <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            if ((total_r[47:32] == '1) && total_sum[32]) begin
              total_r <= TOTAL_MAX;
            end else begin
              total_r <= {total_r[47:32] + 16'(total_sum[32]), total_sum[31:0]};
            end
          end
          busy_flag_r <= 1'b0;
          idle_flag_r <= 1'b1;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (is_query) begin
            if (period_r == '0) begin
              prev_r       <= '0;
              out_result_r <= '{raw_percent: '0, smoothed_percent: '0, total_busy: total_r};
              out_strobe_r <= 1'b1;
            end else begin
              now_r      <= {2'b0, in_req.now_time};
              ws_r       <= {2'b0, in_req.now_time} - {2'b0, period_r};
              limit_r    <= {2'b0, in_req.now_time} - RETAIN34;
              clean_en_r <= $signed(since_clean) >= $signed(RETAIN34);
              if ($signed(since_clean) >= $signed(RETAIN34)) begin
                last_clean_r <= in_req.now_time;
              end
              acc_r <= busy_flag_r ? {{15{open_len[32]}}, open_len} : '0;
              cnt_r <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (cnt_r < CNT_END) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (proc_vld_r && valid_r[proc_idx_r]) begin
            if (seg_add) begin
              acc_r <= acc_r + {{14{seg_delta[33]}}, seg_delta};
            end
            if (clean_en_r && ($signed(seg_e) < $signed(limit_r))) begin
              valid_r[proc_idx_r] <= 1'b0;
            end
          end
        end
        ST_SCALE: begin
          rem_r <= scale_prod;
          bit_r <= DIV_TOP_BIT;
          raw_r <= (acc_pos && !acc_lt) ? PCT_FULL : '0;
        end
        ST_DIV: begin
          raw_r <= {raw_r[13:0], div_ge};
          if (div_ge) begin
            rem_r <= rem_r - div_sub;
          end
          bit_r <= bit_r - 1'b1;
        end
        ST_AVG_MUL: begin
          p1_r <= w_cl * raw_r;
        end
        ST_AVG_SUM: begin
          prev_r       <= smooth;
          out_result_r <= '{raw_percent: raw_r, smoothed_percent: smooth, total_busy: total_r};
          out_strobe_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  `include "channel_busy_percentage_meter_core_assert.svh"

  `CBPM_ASSERT_SAME(a_raw_cap, clk, rst_n, out_strobe, out_result.raw_percent <= PCT_FULL)
  `CBPM_ASSERT_SAME(a_smooth_cap, clk, rst_n, out_strobe, out_result.smoothed_percent <= PCT_FULL)
  `CBPM_ASSERT_NEXT(a_query_busy, clk, rst_n, is_query && (period_r != '0), busy)
  `CBPM_ASSERT_NEXT(a_report_silent, clk, rst_n, is_report && !busy, !out_strobe)
  `CBPM_ASSERT_SAME(a_no_write_in_scan, clk, rst_n, busy, !wr_en)

endmodule
`default_nettype wire
